### rtl/kds_pkg.sv
package kds_pkg;

  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = 4;
  localparam int TIME_BITS = 16;

  localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
  localparam int KEY_BITS  = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
  localparam int LR_BITS   = $clog2(KEY_TOTAL + 1);
  localparam int IN_BITS   = 16;
  localparam int CMP_BITS  = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int PAD_BITS  = 7;

  typedef struct packed {
    logic                 pressed;
    logic [TIME_BITS-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic                 active;
    logic                 closed;
    logic [KEY_BITS-1:0]  key;
    logic [LR_BITS-1:0]   last_rep;
    logic [TIME_BITS-1:0] now;
    logic [15:0]          debounce;
  } head_in_t;

  typedef logic [7:0] legend_row_t [4];
  localparam legend_row_t LEGEND [4] = '{
    '{8'h31, 8'h32, 8'h33, 8'h41},
    '{8'h34, 8'h35, 8'h36, 8'h42},
    '{8'h37, 8'h38, 8'h39, 8'h43},
    '{8'h2a, 8'h30, 8'h23, 8'h44}
  };

  function automatic logic [7:0] key_legend(logic [PAD_BITS-1:0] k);
    int r;
    int c;
    logic [7:0] ch;
    r  = int'(k) / COL_COUNT;
    c  = int'(k) % COL_COUNT;
    ch = 8'h00;
    if (r < 4 && c < 4) begin
      ch = LEGEND[2'(r)][2'(c)];
    end
    return ch;
  endfunction

endpackage

### rtl/kds_cell.sv
module kds_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  kds_pkg::slot_t slot_i,
  output kds_pkg::slot_t slot_o
);
  import kds_pkg::*;

  slot_t slot_q;

  // one key slot of the ring; hands its contents to the neighbor on shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

### rtl/kds_head.sv
module kds_head (
  input  kds_pkg::head_in_t ctl_i,
  input  kds_pkg::slot_t    slot_i,
  output kds_pkg::slot_t    slot_o,
  output logic              hit_o
);
  import kds_pkg::*;

  logic [TIME_BITS-1:0] held;
  logic                 long_enough;
  logic                 new_key;

  assign held        = ctl_i.now - slot_i.stamp;
  assign long_enough = CMP_BITS'(held) >= CMP_BITS'(ctl_i.debounce);
  assign new_key     = LR_BITS'(ctl_i.key) != ctl_i.last_rep;

  always_comb begin
    slot_o = slot_i;
    hit_o  = 1'b0;
    if (ctl_i.active) begin
      if (ctl_i.closed) begin
        if (!slot_i.pressed) begin
          slot_o.pressed = 1'b1;
          slot_o.stamp   = ctl_i.now;
        end else begin
          hit_o = long_enough && new_key;
        end
      end else begin
        slot_o.pressed = 1'b0;
      end
    end
  end

endmodule

### rtl/matrix_keypad_debounce_scanner.sv
// Debounced keypad scanner built as a ring of key cells rotating past one decision head.
// out_valid_o is loaded at the last step of the ring walk, which waits while the output
// register is full. A scan is taken only when the previous one is done; the ring walks
// one key per cycle, stalling only on that last step, and always makes a full turn.
// Reset (rst_ni low, async): all key slots cleared, no key reported, release wait off,
// debounce_ms back to 20.
module matrix_keypad_debounce_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] closed_keys_i,
  input  logic [15:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        key_valid_o,
  output logic [3:0]  key_index_o,
  output logic [7:0]  key_char_o
);
  import kds_pkg::*;

  // configuration
  logic [15:0] debounce_q;

  // scan control
  logic                 busy_q, busy_d;
  logic [KEY_BITS-1:0]  cnt_q, cnt_d;
  logic                 stop_q, stop_d;     // no more state changes this beat
  logic [15:0]          snap_q;
  logic [TIME_BITS-1:0] now_q;
  logic [LR_BITS-1:0]   last_q, last_d;
  logic                 await_q, await_d;
  logic [KEY_BITS-1:0]  held_q, held_d;
  logic                 rep_q, rep_d;       // a key was reported during this beat
  logic [KEY_BITS-1:0]  rep_key_q, rep_key_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 kv_q, kv_d;
  logic [3:0]           ki_q, ki_d;
  logic [7:0]           kc_q, kc_d;

  logic in_acc, last_step, fin_ok, adv, hit, ignore, held_closed, cur_closed;
  logic [PAD_BITS-1:0] held_pad, cnt_pad, rep_pad;

  slot_t    ring   [KEY_TOTAL];
  slot_t    head_out;
  head_in_t hctl;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_step  = cnt_q == KEY_BITS'(KEY_TOTAL - 1);
  assign fin_ok     = !out_valid_q || out_ready_i;
  // the final step also loads the output register, so it waits for a free slot
  assign adv        = busy_q && (!last_step || fin_ok);

  // keys past the snapshot width read as open
  assign held_pad    = PAD_BITS'(held_q);
  assign held_closed = (held_pad < PAD_BITS'(IN_BITS)) && closed_keys_i[held_pad[3:0]];
  assign ignore      = await_q && held_closed;

  assign cnt_pad    = PAD_BITS'(cnt_q);
  assign cur_closed = (cnt_pad < PAD_BITS'(IN_BITS)) && snap_q[cnt_pad[3:0]];

  assign hctl.active   = adv && !stop_q;
  assign hctl.closed   = cur_closed;
  assign hctl.key      = cnt_q;
  assign hctl.last_rep = last_q;
  assign hctl.now      = now_q;
  assign hctl.debounce = debounce_q;

  // cell 0 always holds the key numbered cnt_q
  kds_head u_head (
    .ctl_i  (hctl),
    .slot_i (ring[0]),
    .slot_o (head_out),
    .hit_o  (hit)
  );

  // ring: each cell takes its upper neighbor, the top cell takes the head's result
  for (genvar i = 0; i < KEY_TOTAL; i++) begin : g_cell
    slot_t nxt;
    if (i == KEY_TOTAL - 1) begin : g_top
      assign nxt = head_out;
    end else begin : g_mid
      assign nxt = ring[i+1];
    end
    kds_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (adv),
      .slot_i  (nxt),
      .slot_o  (ring[i])
    );
  end

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    stop_d      = stop_q;
    last_d      = last_q;
    await_d     = await_q;
    held_d      = held_q;
    rep_d       = rep_q;
    rep_key_d   = rep_key_q;
    rep_pad     = PAD_BITS'(rep_key_q);
    out_valid_d = out_valid_q;
    kv_d        = kv_q;
    ki_d        = ki_q;
    kc_d        = kc_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_acc) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      stop_d = ignore;
      rep_d  = 1'b0;
      if (!ignore) begin
        await_d = 1'b0;
      end
    end else if (adv) begin
      cnt_d = cnt_q + KEY_BITS'(1);
      if (hit) begin
        stop_d    = 1'b1;
        rep_d     = 1'b1;
        rep_key_d = cnt_q;
        last_d    = LR_BITS'(cnt_q);
        await_d   = 1'b1;
        held_d    = cnt_q;
      end
      if (last_step) begin
        busy_d  = 1'b0;
        cnt_d   = '0;
        rep_pad = PAD_BITS'(rep_key_d);
        // a full pass without report and without being ignored drops the mark
        if (!stop_d) begin
          last_d = LR_BITS'(KEY_TOTAL);
        end
        out_valid_d = 1'b1;
        kv_d        = rep_d;
        ki_d        = rep_d ? rep_pad[3:0] : 4'd0;
        kc_d        = rep_d ? key_legend(rep_pad) : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= 16'd20;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      last_q      <= LR_BITS'(KEY_TOTAL);
      await_q     <= 1'b0;
      held_q      <= '0;
      rep_q       <= 1'b0;
      rep_key_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_data_i;
      end
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      stop_q      <= stop_d;
      last_q      <= last_d;
      await_q     <= await_d;
      held_q      <= held_d;
      rep_q       <= rep_d;
      rep_key_q   <= rep_key_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scan payload and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      snap_q <= closed_keys_i;
      now_q  <= TIME_BITS'(now_ms_i);
    end
    kv_q <= kv_d;
    ki_q <= ki_d;
    kc_q <= kc_d;
  end

  assign out_valid_o = out_valid_q;
  assign key_valid_o = kv_q;
  assign key_index_o = ki_q;
  assign key_char_o  = kc_q;

  // a fresh beat starts the ring walk at key zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && (cnt_q == '0))
    else $error("scan did not start at key zero");

  // once the scan has stopped it stays stopped until the beat ends
  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && stop_q && !(adv && last_step) |=> stop_q)
    else $error("stopped scan resumed");

  // the ring is back in place whenever the block is idle
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0)
    else $error("ring left misaligned");

  // a report always arms the release wait
  a_rep_await: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && hit |=> await_q && rep_q)
    else $error("report without release wait");

endmodule
